>>> hdl/hlfa_pkg.sv
// Package with the header constants and result type of the header-length frame assembler.
package hlfa_pkg;

  localparam logic [7:0] HDR_FIRST  = 8'hA5;
  localparam logic [7:0] HDR_SECOND = 8'h5A;
  localparam logic [8:0] POS_FIRST  = 9'd0;
  localparam logic [8:0] POS_SECOND = 9'd1;
  localparam logic [8:0] LEN_POS    = 9'd2;
  localparam logic [8:0] HDR_TOTAL  = 9'd3;

  typedef struct packed {
    logic       stored;
    logic [7:0] data_byte;
    logic [8:0] position;
    logic       frame_done;
    logic [8:0] frame_length;
  } result_t;

endpackage

>>> hdl/header_length_frame_assembler_top.sv
// Header-length frame assembler: one result per received byte, with frame position and length.
//
// Takes one received byte per clock cycle while the output side takes results, and gives exactly one result item for
// each byte: a flag that says whether the byte belongs to the current frame
// (header 0xA5 0x5A, a length byte N, then N payload bytes), the byte and its
// position in the frame, and on the last byte of a frame the total length N+3.
// A header byte that does not match is dropped and restarts the header search;
// that byte is not taken as the start of a new header. A byte is accepted
// when the output register is empty or its result is being taken; the compare
// and increment on the frame count settle in the cycle the byte is accepted,
// and the result is written to the output register at the end of that cycle,
// so throughput is one item per cycle while the output side takes results.
module header_length_frame_assembler_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       stored,
  output logic [7:0] data_byte,
  output logic [8:0] position,
  output logic       frame_done,
  output logic [8:0] frame_length
);

  import hlfa_pkg::*;

  logic [8:0] byte_count;
  logic [8:0] byte_count_next;
  logic [7:0] payload_length;
  logic [7:0] payload_length_next;
  result_t    result;
  result_t    result_next;
  logic       in_accept;
  logic       mismatch;
  logic [7:0] length_now;
  logic [9:0] last_pos;
  logic       done;

  assign in_ready  = !out_valid || out_ready;
  assign in_accept = in_valid && in_ready;

  always_comb begin
    mismatch   = ((byte_count == POS_FIRST) && (rx_byte != HDR_FIRST)) ||
                 ((byte_count == POS_SECOND) && (rx_byte != HDR_SECOND));
    length_now = (byte_count == LEN_POS) ? rx_byte : payload_length;
    last_pos   = {2'b00, length_now} + {1'b0, HDR_TOTAL} - 10'd1;
    done       = !mismatch && (byte_count >= LEN_POS) && ({1'b0, byte_count} >= last_pos);

    result_next = '0;
    if (!mismatch) begin
      result_next.stored    = 1'b1;
      result_next.data_byte = rx_byte;
      result_next.position  = byte_count;
    end
    if (done) begin
      result_next.frame_done   = 1'b1;
      result_next.frame_length = {1'b0, length_now} + HDR_TOTAL;
    end

    if (mismatch || done) begin
      byte_count_next     = '0;
      payload_length_next = '0;
    end else begin
      byte_count_next     = byte_count + 9'd1;
      payload_length_next = length_now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count     <= '0;
      payload_length <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (in_accept) begin
        byte_count     <= byte_count_next;
        payload_length <= payload_length_next;
        out_valid      <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      result <= result_next;
    end
  end

  assign stored       = result.stored;
  assign data_byte    = result.data_byte;
  assign position     = result.position;
  assign frame_done   = result.frame_done;
  assign frame_length = result.frame_length;

  a_done_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_done |-> stored && (frame_length == position + 9'd1))
    else $error("frame length does not match position of last byte");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    byte_count > LEN_POS |-> {1'b0, byte_count} < {2'b00, payload_length} + 10'd3)
    else $error("frame count ran past frame length");

  a_drop_restart: assert property (@(posedge clk) disable iff (rst)
    in_accept && !result_next.stored |=> byte_count == 9'd0)
    else $error("dropped byte did not restart header search");

  a_drop_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && !stored |-> !frame_done && (position == 9'd0) && (data_byte == 8'd0))
    else $error("dropped byte carries frame data");

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the header-length frame assembler.
module tb_top;
  import hlfa_pkg::*;

  localparam int NUM_ITEMS     = 1450;
  localparam int SETTLE_CYCLES = 10;
  localparam int RESET_CYCLES  = 10;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  logic [7:0] rx_byte   = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       stored;
  logic [7:0] data_byte;
  logic [8:0] position;
  logic       frame_done;
  logic [8:0] frame_length;

  logic [7:0] rx_pending[$];
  result_t    expected_results[$];
  int         total_bytes = 0;
  int         bytes_sent  = 0;
  int         stim_items  = 0;
  int         errors      = 0;
  logic [8:0] asm_count   = '0;
  logic [7:0] asm_len     = '0;

  header_length_frame_assembler_top u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .stored       (stored),
    .data_byte    (data_byte),
    .position     (position),
    .frame_done   (frame_done),
    .frame_length (frame_length)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic result_t assemble_byte(logic [7:0] b);
    result_t    r;
    logic [8:0] pos;
    r   = '0;
    pos = asm_count;
    if ((pos == POS_FIRST && b != HDR_FIRST) || (pos == POS_SECOND && b != HDR_SECOND)) begin
      asm_count = '0;
      asm_len   = '0;
      return r;
    end
    r.stored    = 1'b1;
    r.data_byte = b;
    r.position  = pos;
    if (pos == LEN_POS) begin
      asm_len = b;
    end
    asm_count = pos + 9'd1;
    if (pos >= LEN_POS && int'(pos) >= int'(asm_len) + int'(HDR_TOTAL) - 1) begin
      r.frame_done   = 1'b1;
      r.frame_length = {1'b0, asm_len} + HDR_TOTAL;
      asm_count      = '0;
      asm_len        = '0;
    end
    return r;
  endfunction

  // Percent of cycles one side idles, by thirds of the stream.
  function automatic int idle_pct(bit sender);
    int phase;
    phase = (bytes_sent * 3) / (total_bytes > 0 ? total_bytes : 1);
    if (phase == 0) begin
      return sender ? 14 : 72;
    end
    if (phase == 1) begin
      return sender ? 72 : 14;
    end
    return 0;
  endfunction

  task automatic check_field(string name, logic [8:0] exp_v, logic [8:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  task automatic push_frame(int len, int keep);
    rx_pending.push_back(HDR_FIRST);
    rx_pending.push_back(HDR_SECOND);
    rx_pending.push_back(8'(len));
    for (int i = 0; i < keep; i++) begin
      rx_pending.push_back(8'($urandom_range(255)));
    end
    stim_items += 3 + keep;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_results.push_back(assemble_byte(rx_byte));
        bytes_sent <= bytes_sent + 1;
      end
      if (!in_valid || in_ready) begin
        if (rx_pending.size() > 0 && $urandom_range(99) >= idle_pct(1'b1)) begin
          in_valid <= 1'b1;
          rx_byte  <= rx_pending.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    result_t exp_r;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: no item pending");
          errors++;
        end else begin
          exp_r = expected_results.pop_front();
          check_field("stored", 9'(exp_r.stored), 9'(stored));
          check_field("data_byte", 9'(exp_r.data_byte), 9'(data_byte));
          check_field("position", exp_r.position, position);
          check_field("frame_done", 9'(exp_r.frame_done), 9'(frame_done));
          check_field("frame_length", exp_r.frame_length, frame_length);
        end
      end
      out_ready <= ($urandom_range(99) >= idle_pct(1'b0));
    end
  end

  initial begin
    logic [7:0] directed[] = '{
      8'hA5, 8'h5A, 8'h00,
      8'hA5, 8'h5A, 8'h01, 8'hFF,
      8'h00,
      8'hA5, 8'hA5,
      8'h5A,
      8'hA5, 8'h5A, 8'h02, 8'h00, 8'hA5,
      8'hA5, 8'hFF,
      8'hA5, 8'h5A, 8'h03, 8'h5A, 8'hA5, 8'h00
    };
    int kind;
    int len;
    int big_frames;

    foreach (directed[i]) begin
      rx_pending.push_back(directed[i]);
    end
    stim_items = directed.size();

    push_frame(255, 255);
    big_frames = 1;
    while (stim_items < NUM_ITEMS) begin
      kind = $urandom_range(99);
      if (kind < 75) begin
        if (big_frames < 3 && stim_items + 258 <= NUM_ITEMS && $urandom_range(59) == 0) begin
          len = 255;
          big_frames++;
        end else begin
          len = $urandom_range(12);
        end
        push_frame(len, len);
      end else if (kind < 85) begin
        len = $urandom_range(12);
        push_frame(len, $urandom_range(len));
      end else if (kind < 92) begin
        rx_pending.push_back(HDR_FIRST);
        rx_pending.push_back(8'($urandom_range(255)));
        stim_items += 2;
      end else begin
        len = $urandom_range(4, 1);
        repeat (len) rx_pending.push_back(8'($urandom_range(255)));
        stim_items += len;
      end
    end
    total_bytes = rx_pending.size();

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    while (rx_pending.size() > 0 || in_valid) @(posedge clk);
    while (expected_results.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
